// ===== hdl/lzsr_pkg.sv =====
// Shared definitions for the longest zero-sum run block.
// Holds default sizes, fixed result widths and the cell control struct.
// No dependencies.
package lzsr_pkg;

  // Default array length limit and element width
  localparam int unsigned MaxLenDef   = 1024;
  localparam int unsigned ElemBitsDef = 16;

  // Result item layout: best_len, then overflow, padded to whole bytes
  localparam int unsigned BestLenW = 11;
  localparam int unsigned OutDataW = 16;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic rotate;  // shift the occupied cells one step toward cell 0
    logic load;    // write the broadcast entry into the first free cell
  } lzsr_ctl_t;

endpackage

// ===== hdl/lzsr_cell.sv =====
// One cell of the prefix-sum chain: holds a seen sum and its first position.
// Depends on lzsr_pkg for the control struct.
module lzsr_cell #(
  parameter int unsigned SUM_W  = 26,
  parameter int unsigned SPOS_W = 10,
  parameter int unsigned CNT_W  = 11,
  parameter int unsigned IDX    = 0
) (
  input  logic                    clk_i,
  input  lzsr_pkg::lzsr_ctl_t     ctl_i,
  input  logic [CNT_W-1:0]        cnt_i,
  input  logic signed [SUM_W-1:0] new_sum_i,
  input  logic [SPOS_W-1:0]       new_pos_i,
  input  logic signed [SUM_W-1:0] nxt_sum_i,
  input  logic [SPOS_W-1:0]       nxt_pos_i,
  input  logic signed [SUM_W-1:0] wrap_sum_i,
  input  logic [SPOS_W-1:0]       wrap_pos_i,
  output logic signed [SUM_W-1:0] sum_o,
  output logic [SPOS_W-1:0]       pos_o
);
  import lzsr_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] TailCnt = CNT_W'(IDX + 1);

  logic signed [SUM_W-1:0] sum_q;
  logic [SPOS_W-1:0]       pos_q;
  logic                    occupied;
  logic                    is_tail;

  assign occupied = (cnt_i > MyIdx);
  assign is_tail  = (cnt_i == TailCnt);

  // Tail cell takes the head entry back so the occupied ring stays closed
  always_ff @(posedge clk_i) begin
    if (ctl_i.load && (cnt_i == MyIdx)) begin
      sum_q <= new_sum_i;
      pos_q <= new_pos_i;
    end else if (ctl_i.rotate && occupied) begin
      if (is_tail) begin
        sum_q <= wrap_sum_i;
        pos_q <= wrap_pos_i;
      end else begin
        sum_q <= nxt_sum_i;
        pos_q <= nxt_pos_i;
      end
    end
  end

  assign sum_o = sum_q;
  assign pos_o = pos_q;

endmodule

// ===== hdl/longest_zero_sum_run_top.sv =====
// Longest zero-sum run: control, running sum and the chain of table cells.
// An excess or zero-sum item goes straight to the result state; any other item first scans
// the chain, rotating it until cell 0 matches or every entry is checked, then posts its result.
// The next item is taken the cycle after its result posts, so only one item is in flight;
// a result held by the receiver stalls the sequencer and the input.
// Reset clears sum, position, best length, fill count and overflow; cells keep stale data.
module longest_zero_sum_run_top #(
  parameter int unsigned MAX_LEN   = lzsr_pkg::MaxLenDef,
  parameter int unsigned ELEM_BITS = lzsr_pkg::ElemBitsDef,
  localparam int unsigned InDataW  = ((ELEM_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side: one array element per item
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [InDataW-1:0]            s_axis_tdata,   // [ELEM_BITS-1:0] value
  input  logic                          s_axis_tlast,   // last element of the array
  // master side: one result per item
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lzsr_pkg::OutDataW-1:0] m_axis_tdata    // [10:0] best_len, [11] overflow
);
  import lzsr_pkg::*;

  // Sizes that follow from the parameters
  localparam int unsigned SumW  = ELEM_BITS + $clog2(MAX_LEN);
  localparam int unsigned SPosW = $clog2(MAX_LEN);
  localparam int unsigned CntW  = $clog2(MAX_LEN + 1);
  localparam int unsigned PadW  = OutDataW - BestLenW - 1;

  localparam logic [CntW-1:0] MaxPos = CntW'(MAX_LEN);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  state_e                 state_q;
  logic signed [SumW-1:0] sum_q;      // running prefix sum
  logic [CntW-1:0]        pos_q;      // elements taken in this array
  logic [CntW-1:0]        best_q;     // best run length so far
  logic [CntW-1:0]        cnt_q;      // occupied cells in the chain
  logic [CntW-1:0]        scan_q;     // entries checked for this item
  logic                   ovf_q;
  logic                   last_q;
  logic                   out_vld_q;
  logic [BestLenW-1:0]    out_best_q;
  logic                   out_ovf_q;

  logic                   in_acc;
  logic signed [SumW-1:0] elem_ext;
  logic signed [SumW-1:0] sum_nxt;
  logic                   hit;
  logic [CntW-1:0]        run_gap;
  lzsr_ctl_t              ctl;

  // Chain contents, cell 0 is the compare point
  logic signed [SumW-1:0] cell_sum [MAX_LEN];
  logic [SPosW-1:0]       cell_pos [MAX_LEN];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Sign-extend the element and advance the prefix sum
  assign elem_ext = {{(SumW - ELEM_BITS){s_axis_tdata[ELEM_BITS-1]}},
                     s_axis_tdata[ELEM_BITS-1:0]};
  assign sum_nxt  = sum_q + elem_ext;

  // Sums in the chain are unique, so the first match is the only one
  assign hit     = (cell_sum[0] == sum_q);
  assign run_gap = pos_q - CntW'(cell_pos[0]);

  always_comb begin
    ctl.rotate = (state_q == ST_SEARCH) && (scan_q != cnt_q) && !hit;
    ctl.load   = (state_q == ST_SEARCH) && (scan_q == cnt_q);
  end

  // Row of cells; the last cell links back to cell 0
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    localparam int unsigned NxtIdx = (k + 1 < MAX_LEN) ? k + 1 : 0;
    lzsr_cell #(
      .SUM_W  (SumW),
      .SPOS_W (SPosW),
      .CNT_W  (CntW),
      .IDX    (k)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .cnt_i      (cnt_q),
      .new_sum_i  (sum_q),
      .new_pos_i  (pos_q[SPosW-1:0]),
      .nxt_sum_i  (cell_sum[NxtIdx]),
      .nxt_pos_i  (cell_pos[NxtIdx]),
      .wrap_sum_i (cell_sum[0]),
      .wrap_pos_i (cell_pos[0]),
      .sum_o      (cell_sum[k]),
      .pos_o      (cell_pos[k])
    );
  end

  // Sequencer: take an item, scan the chain, post the result, clear on last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sum_q      <= '0;
      pos_q      <= '0;
      best_q     <= '0;
      cnt_q      <= '0;
      scan_q     <= '0;
      ovf_q      <= 1'b0;
      last_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      out_best_q <= '0;
      out_ovf_q  <= 1'b0;
    end else begin
      // Drop the result once taken; the result state posts the next one itself
      if (out_vld_q && m_axis_tready && (state_q != ST_RESULT)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            last_q <= s_axis_tlast;
            if (pos_q == MaxPos) begin
              // Excess element: ignore it, flag overflow
              ovf_q   <= 1'b1;
              state_q <= ST_RESULT;
            end else begin
              sum_q <= sum_nxt;
              if (sum_nxt == '0) begin
                // Whole prefix sums to zero
                best_q  <= pos_q + CntOne;
                pos_q   <= pos_q + CntOne;
                state_q <= ST_RESULT;
              end else begin
                scan_q  <= '0;
                state_q <= ST_SEARCH;
              end
            end
          end
        end
        ST_SEARCH: begin
          if (scan_q == cnt_q) begin
            // Not seen before: the free cell takes it this cycle
            cnt_q   <= cnt_q + CntOne;
            pos_q   <= pos_q + CntOne;
            state_q <= ST_RESULT;
          end else if (hit) begin
            if (run_gap > best_q) begin
              best_q <= run_gap;
            end
            pos_q   <= pos_q + CntOne;
            state_q <= ST_RESULT;
          end else begin
            scan_q <= scan_q + CntOne;
          end
        end
        ST_RESULT: begin
          // Hold until the output register is free
          if (!out_vld_q || m_axis_tready) begin
            out_vld_q  <= 1'b1;
            out_best_q <= BestLenW'(best_q);
            out_ovf_q  <= ovf_q;
            if (last_q) begin
              sum_q  <= '0;
              pos_q  <= '0;
              best_q <= '0;
              cnt_q  <= '0;
              ovf_q  <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_ovf_q, out_best_q};

`ifndef SYNTHESIS
  // Each stored sum came from a distinct element
  a_cnt_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pos_q)
    else $error("fill count exceeds position");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos)
    else $error("position beyond array limit");

  // The scan never walks past the occupied cells
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (scan_q <= cnt_q))
    else $error("scan index beyond fill count");

  // Overflow is only raised once the array limit is reached
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (pos_q == MaxPos))
    else $error("overflow set below array limit");
`endif

endmodule

// ===== tb/tb_longest_zero_sum_run_top.sv =====
// Testbench for longest_zero_sum_run_top: streams arrays in, checks best length and overflow.
// Predicts every result with its own prefix-sum table; depends on lzsr_pkg and the block only.
`timescale 1ns / 100ps

module tb_longest_zero_sum_run_top;
  import lzsr_pkg::*;

  localparam int unsigned MaxLen     = MaxLenDef;
  localparam int unsigned InDataW    = ((ElemBitsDef + 7) / 8) * 8;
  // Watchdog limit on the whole run, set well above the slowest legal run.
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned HoldOff    = 400;

  // Expected result of one item
  typedef struct packed {
    logic [BestLenW-1:0] best_len;
    logic                overflow;
  } run_len_t;

  // How the elements of one random array are drawn
  typedef enum int {
    ValSmall,
    ValFull,
    ValMirror,
    ValEdge
  } val_style_e;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // [15:0] value
  logic                s_axis_tlast  = 1'b0;  // last element of the array
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;          // [10:0] best_len, [11] overflow

  // Predictor state: mirrors what the block holds for the current array
  longint           acc_sum;
  int               elem_pos;
  int               longest;
  int               table_fill;
  bit               excess_seen;
  int               first_pos_of_sum[longint];

  run_len_t         pending_results[$];
  int               error_count      = 0;
  int unsigned      cycle_count      = 0;
  int               burst_left       = 0;
  int               hold_off_request = 0;

  longest_zero_sum_run_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles for the watchdog
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("longest_zero_sum_run_top test failed");
    $finish;
  end

  // Reset every piece of the predicted array state, as the block does after a last item
  function automatic void clear_prediction();
    acc_sum     = 0;
    elem_pos    = 0;
    longest     = 0;
    table_fill  = 0;
    excess_seen = 1'b0;
    first_pos_of_sum.delete();
  endfunction

  // Advance the prediction by one element and return the result it causes
  function automatic run_len_t predict_run_length(input logic signed [15:0] value, input bit lst);
    run_len_t res;
    if (elem_pos >= MaxLen) begin
      // Excess element: ignored apart from raising the overflow flag
      excess_seen = 1'b1;
    end else begin
      acc_sum += longint'(value);
      if (acc_sum == 0) begin
        longest = elem_pos + 1;
      end else if (first_pos_of_sum.exists(acc_sum)) begin
        // A repeated sum keeps its first position; the run spans the gap
        if (elem_pos - first_pos_of_sum[acc_sum] > longest)
          longest = elem_pos - first_pos_of_sum[acc_sum];
      end else if (table_fill < MaxLen) begin
        first_pos_of_sum[acc_sum] = elem_pos;
        table_fill++;
      end
      elem_pos++;
    end
    res.best_len = BestLenW'(longest);
    res.overflow = excess_seen;
    if (lst) clear_prediction();
    return res;
  endfunction

  // Offer one item; the sender runs in bursts with random gaps between them.
  // Enter and leave on a rising edge.
  task automatic send_elem(input logic signed [15:0] value, input bit lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(value);
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_run_length(value, lst));
  endtask

  // Stop offering and hold until every expected result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: long hold-off on request, otherwise stall patterns that change now and then
  initial begin
    int hold_left;
    int mode_left;
    int ready_pct;
    hold_left = 0;
    mode_left = 0;
    ready_pct = 100;
    forever begin
      @(posedge clk_i);
      if (hold_off_request > 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 200);
          case ($urandom_range(4))
            0, 1:    ready_pct = 100;
            2:       ready_pct = 70;
            3:       ready_pct = 40;
            default: ready_pct = 10;
          endcase
        end
        mode_left--;
        m_axis_tready <= ($urandom_range(99) < ready_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    run_len_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: tdata %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[BestLenW-1:0] !== want.best_len) begin
          $error("best_len: expected %0d, got %0d", want.best_len, m_axis_tdata[BestLenW-1:0]);
          error_count++;
        end
        if (m_axis_tdata[BestLenW] !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, m_axis_tdata[BestLenW]);
          error_count++;
        end
      end
    end
  end

  // Extremes of the element, zero first element, repeated sums and nested zero runs
  task automatic test_directed();
    send_elem(16'sd0, 1'b1);
    send_elem(16'sd32767, 1'b1);
    send_elem(-16'sd32768, 1'b1);
    // sums 32767, -1, 0: the whole array cancels
    send_elem(16'sd32767, 1'b0);
    send_elem(-16'sd32768, 1'b0);
    send_elem(16'sd1, 1'b1);
    // a sum seen three times keeps its first position
    send_elem(16'sd5, 1'b0);
    send_elem(16'sd0, 1'b0);
    send_elem(16'sd0, 1'b0);
    send_elem(-16'sd5, 1'b0);
    send_elem(16'sd3, 1'b0);
    send_elem(-16'sd3, 1'b1);
    send_elem(-16'sd1, 1'b0);
    send_elem(16'sd1, 1'b0);
    send_elem(-16'sd1, 1'b0);
    send_elem(16'sd1, 1'b0);
    send_elem(16'sd1, 1'b1);
    // prefix sums beyond the element width
    send_elem(16'sd32767, 1'b0);
    send_elem(16'sd32767, 1'b0);
    send_elem(-16'sd32767, 1'b0);
    send_elem(-16'sd32767, 1'b1);
    drain();
  endtask

  // Full-length array that cancels to zero (best length at its top value),
  // then excess elements, the final one carrying the last mark
  task automatic test_full_span_and_excess();
    for (int i = 0; i < MaxLen / 2; i++) send_elem(16'sd1, 1'b0);
    for (int i = 0; i < MaxLen / 2; i++) send_elem(-16'sd1, 1'b0);
    send_elem(16'($urandom), 1'b0);
    send_elem(16'($urandom), 1'b0);
    send_elem(16'($urandom), 1'b1);
    drain();
  endtask

  // Hold the receiver off for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_off_request = HoldOff;
    for (int i = 0; i < 40; i++)
      send_elem(16'(int'($urandom_range(6)) - 3), i == 39);
    drain();
  endtask

  function automatic logic signed [15:0] draw_value(input val_style_e style);
    case (style)
      ValSmall: return 16'(int'($urandom_range(4)) - 2);
      ValFull:  return 16'($urandom);
      ValEdge: begin
        case ($urandom_range(4))
          0:       return -16'sd32768;
          1:       return 16'sd32767;
          2:       return 16'sd1;
          3:       return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      default:  return 16'(int'($urandom_range(65534)) - 32767);
    endcase
  endfunction

  // Random arrays, mostly short, with styles that make zero-sum runs common
  task automatic test_random_arrays(input int item_budget);
    logic signed [15:0] elems[$];
    val_style_e         style;
    int                 sent;
    int                 len;
    int                 pick;
    int                 pause_at;
    sent     = 0;
    pause_at = 40;
    while (sent < item_budget) begin
      elems.delete();
      pick = $urandom_range(19);
      if (pick < 14) len = $urandom_range(1, 16);
      else if (pick < 19) len = $urandom_range(17, 64);
      else len = $urandom_range(65, 160);
      style = val_style_e'($urandom_range(3));
      if (style == ValMirror) begin
        // first half, an optional middle, then the first half negated in reverse
        for (int i = 0; i < len / 2; i++) elems.push_back(draw_value(style));
        if (len % 2 == 1) elems.push_back(draw_value(ValSmall));
        for (int i = len / 2 - 1; i >= 0; i--) elems.push_back(-elems[i]);
      end else begin
        for (int i = 0; i < len; i++) elems.push_back(draw_value(style));
      end
      foreach (elems[i]) send_elem(elems[i], i == elems.size() - 1);
      sent += elems.size();
      // pause the sender now and then until every result is back
      if (sent >= pause_at) begin
        drain();
        pause_at += 40;
      end
    end
    drain();
  endtask

  initial begin
    clear_prediction();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_span_and_excess();
    test_backpressure();
    test_random_arrays(80);

    // let any stray result show up before the verdict
    repeat (MaxLen + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("longest_zero_sum_run_top test passed");
    end else begin
      $display("longest_zero_sum_run_top test failed");
    end
    $finish;
  end

endmodule
